// ===== hdl/blpq_pkg.sv =====
// Types and constants shared by the button long-press event queue.
`timescale 1ns / 1ps

package blpq_pkg;

	typedef logic [1:0] func_t;
	typedef logic [1:0] action_t;
	typedef logic [15:0] code_t;
	typedef logic [15:0] ticks_t;
	typedef logic [31:0] stamp_t;

	localparam func_t FUNC_TICK   = 2'd0;
	localparam func_t FUNC_PACKET = 2'd1;
	localparam func_t FUNC_POP    = 2'd2;

	localparam int BUTTON_COUNT = 3;

	// Index 0 end-cap (single), 1 down (double), 2 up (long).
	localparam logic [BUTTON_COUNT-1:0][15:0] PRESS_CODES   = {16'hA301, 16'hA201, 16'hA101};
	localparam logic [BUTTON_COUNT-1:0][15:0] RELEASE_CODES = {16'hA300, 16'hA200, 16'hA100};

	localparam ticks_t LONG_PRESS_RESET = 16'd750;

	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		func_t       func;
		logic [7:0]  byte_first;
		logic [7:0]  byte_second;
		logic [7:0]  byte_third;
		logic [1:0]  packet_length;
	} in_item_t;

	typedef struct packed {
		logic        popped_valid;
		action_t     popped_action;
		logic [2:0]  queue_count;
		logic        dropped_oldest;
	} out_item_t;

	// Ring status after the current operation.
	typedef struct packed {
		logic        popped_valid;
		logic        dropped;
		logic [2:0]  count;
	} ring_stat_t;

endpackage

// ===== hdl/blpq_in_if.sv =====
// Input item channel of the button long-press event queue.
`timescale 1ns / 1ps

interface blpq_in_if;
	logic                valid;
	logic                ready;
	blpq_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/blpq_out_if.sv =====
// Result item channel of the button long-press event queue.
`timescale 1ns / 1ps

interface blpq_out_if;
	logic                 valid;
	logic                 ready;
	blpq_pkg::out_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/blpq_cfg_if.sv =====
// Configuration write channel of the button long-press event queue.
`timescale 1ns / 1ps

interface blpq_cfg_if;
	logic              valid;
	logic              ready;
	blpq_pkg::ticks_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/blpq_ring.sv =====
// Action ring queue: head/tail pointers around a synchronous action memory.
`timescale 1ns / 1ps

module blpq_ring #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  push,
	input  blpq_pkg::action_t     push_action,
	input  logic                  pop,
	output blpq_pkg::ring_stat_t  stat,
	output blpq_pkg::action_t     rd_action
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

	blpq_pkg::action_t mem [QUEUE_DEPTH];
	blpq_pkg::action_t rd_q;

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [PTR_W-1:0] head_inc, tail_inc;
	logic             full, not_empty, do_push, do_pop;
	logic [PTR_W:0]   count_d;
	logic [PTR_W+3:0] count_ext;

	assign head_inc  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
	assign full      = (tail_inc == head_q);
	assign not_empty = (head_q != tail_q);
	assign do_push   = step && push;
	assign do_pop    = step && pop && not_empty;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		if (do_push) begin
			tail_d = tail_inc;
			if (full) begin
				head_d = head_inc;
			end
		end else if (do_pop) begin
			head_d = head_inc;
		end
	end

	always_comb begin
		if (tail_d >= head_d) begin
			count_d = {1'b0, tail_d} - {1'b0, head_d};
		end else begin
			count_d = {1'b0, tail_d} + DEPTH_EXT - {1'b0, head_d};
		end
		count_ext = {3'b000, count_d};
	end

	assign stat.popped_valid = do_pop;
	assign stat.dropped      = do_push && full;
	assign stat.count        = count_ext[2:0];
	assign rd_action         = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (step) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// Write at the tail, read the head into a registered port.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= push_action;
		end
		if (do_pop) begin
			rd_q <= mem[head_q];
		end
	end

endmodule

// ===== hdl/button_long_press_event_queue_unit.sv =====
// Top level of the button long-press event queue: press tracking and result register.
`timescale 1ns / 1ps

// Usage:
// - req carries one item per beat: a tick (advance the millisecond counter),
//   a notify packet (match press/release codes of three buttons) or a pop.
// - rsp returns exactly one result beat per request beat, in order: the
//   popped action if any, the queue fill after the item, and a drop flag
//   when an enqueue pushed out the oldest action.
// - cfg writes long_press_ticks; it is always ready and should be written
//   only while no request is outstanding.
// - The result is registered: a beat accepted at edge n shows its result after
//   that edge. Throughput is one item per cycle while rsp does not stall; the
//   ring pointers are read, modified and written back in the same cycle, and
//   the action memory read lands directly in the result register.
// - When rsp stalls, the result register holds and req.ready drops; a taken
//   result frees the register in the same cycle a new beat is accepted.
// - Reset clears the counter, press flags, stamps and ring pointers and
//   loads long_press_ticks with 750. The action memory is not cleared; only
//   written entries are ever read.
module button_long_press_event_queue_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	blpq_in_if.sink     req,
	blpq_out_if.source  rsp,
	blpq_cfg_if.sink    cfg
);

	localparam int NB = blpq_pkg::BUTTON_COUNT;

	blpq_pkg::ticks_t   ticks_q;
	blpq_pkg::stamp_t   now_q;
	blpq_pkg::stamp_t   stamp_q [NB];
	logic [NB-1:0]      seen_q;

	logic               rsp_valid_q;
	logic               popped_valid_q;
	logic [2:0]         count_q;
	logic               dropped_q;

	logic               step;
	logic               is_packet;
	logic               code_ok;
	blpq_pkg::code_t    code16;
	logic [NB-1:0]      press_hit, rel_hit, rel_long;
	logic               push;
	blpq_pkg::action_t  push_action;
	blpq_pkg::ring_stat_t ring_stat;
	blpq_pkg::action_t  rd_action;
	blpq_pkg::stamp_t   elapsed [NB];

	// Accept when the result register is empty or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign step      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= blpq_pkg::LONG_PRESS_RESET;
		end else if (cfg.valid) begin
			ticks_q <= cfg.data;
		end
	end

	// Form the 16-bit code; a three-byte packet matches only with a zero lead byte.
	always_comb begin
		is_packet = (req.data.func == blpq_pkg::FUNC_PACKET);
		code16    = {req.data.byte_first, req.data.byte_second};
		code_ok   = 1'b0;
		case (req.data.packet_length)
			blpq_pkg::LEN_TWO: begin
				code_ok = is_packet;
			end
			blpq_pkg::LEN_THREE: begin
				code16  = {req.data.byte_second, req.data.byte_third};
				code_ok = is_packet && (req.data.byte_first == 8'h00);
			end
			default: begin
				code_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			elapsed[i]   = now_q - stamp_q[i];
			press_hit[i] = code_ok && (code16 == blpq_pkg::PRESS_CODES[i]);
			rel_hit[i]   = code_ok && (code16 == blpq_pkg::RELEASE_CODES[i]) && seen_q[i];
			rel_long[i]  = rel_hit[i] && (elapsed[i] >= {16'h0000, ticks_q});
		end
	end

	// Codes are distinct, so at most one button enqueues per packet.
	always_comb begin
		push        = 1'b0;
		push_action = '0;
		for (int i = 0; i < NB; i++) begin
			if (press_hit[i] || rel_long[i]) begin
				push        = 1'b1;
				push_action = 2'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			seen_q <= '0;
			for (int i = 0; i < NB; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (step) begin
			if (req.data.func == blpq_pkg::FUNC_TICK) begin
				now_q <= now_q + 32'd1;
			end
			for (int i = 0; i < NB; i++) begin
				if (press_hit[i]) begin
					stamp_q[i] <= now_q;
					seen_q[i]  <= 1'b1;
				end else if (rel_hit[i]) begin
					stamp_q[i] <= '0;
					seen_q[i]  <= 1'b0;
				end
			end
		end
	end

	blpq_ring #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.push        (push),
		.push_action (push_action),
		.pop         (req.data.func == blpq_pkg::FUNC_POP),
		.stat        (ring_stat),
		.rd_action   (rd_action)
	);

	// Result register: load on accept, hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			popped_valid_q <= ring_stat.popped_valid;
			count_q        <= ring_stat.count;
			dropped_q      <= ring_stat.dropped;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.data.popped_valid   = popped_valid_q;
	assign rsp.data.popped_action  = popped_valid_q ? rd_action : '0;
	assign rsp.data.queue_count    = count_q;
	assign rsp.data.dropped_oldest = dropped_q;

endmodule

// ===== sim/blpq_event_checker.sv =====
// Result checker for the button long-press event queue: beat monitor, action predictor, compare.
`timescale 1ns / 1ps

import blpq_pkg::*;

module blpq_event_checker #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	blpq_in_if   req,
	blpq_out_if  rsp,
	blpq_cfg_if  cfg,
	output int   failures,
	output int   outstanding
);

	ticks_t      hold_min;
	stamp_t      clock_ms;
	stamp_t      held_since [BUTTON_COUNT];
	logic        held       [BUTTON_COUNT];
	action_t     ring       [QUEUE_DEPTH];
	int unsigned head;
	int unsigned tail;
	out_item_t   pending_results [$];
	out_item_t   oldest;
	int          error_tally;

	assign failures = error_tally;

	// Append an action; a full ring gives up its oldest entry.
	function automatic logic push_action(action_t act);
		logic lost;
		lost = 1'b0;
		if ((tail + 1) % QUEUE_DEPTH == head) begin
			head = (head + 1) % QUEUE_DEPTH;
			lost = 1'b1;
		end
		ring[tail] = act;
		tail = (tail + 1) % QUEUE_DEPTH;
		return lost;
	endfunction

	function automatic out_item_t predict_item(in_item_t it);
		out_item_t   res;
		logic [23:0] code;
		res = '0;
		case (it.func)
			FUNC_TICK: begin
				clock_ms = clock_ms + 1;
			end
			FUNC_PACKET: begin
				// Bytes are big-endian; drop the ones beyond the packet length.
				code = {it.byte_first, it.byte_second, it.byte_third} >> (8 * (3 - it.packet_length));
				for (int b = 0; b < BUTTON_COUNT; b++) begin
					if (code == {8'h00, PRESS_CODES[b]}) begin
						held_since[b] = clock_ms;
						held[b] = 1'b1;
						res.dropped_oldest |= push_action(action_t'(b));
					end else if (code == {8'h00, RELEASE_CODES[b]} && held[b]) begin
						if (clock_ms - held_since[b] >= stamp_t'(hold_min))
							res.dropped_oldest |= push_action(action_t'(b));
						held[b] = 1'b0;
						held_since[b] = '0;
					end
				end
			end
			FUNC_POP: begin
				if (head != tail) begin
					res.popped_valid = 1'b1;
					res.popped_action = ring[head];
					head = (head + 1) % QUEUE_DEPTH;
				end
			end
			default: begin
			end
		endcase
		res.queue_count = 3'((tail + QUEUE_DEPTH - head) % QUEUE_DEPTH);
		return res;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_min = LONG_PRESS_RESET;
			clock_ms = '0;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				held_since[b] = '0;
				held[b] = 1'b0;
			end
			head = 0;
			tail = 0;
			pending_results.delete();
			error_tally = 0;
			outstanding <= 0;
		end else begin
			// Results come back only after their items are accepted: check before predicting.
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no item outstanding");
					error_tally++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("popped_valid", oldest.popped_valid, rsp.data.popped_valid);
					check_field("popped_action", oldest.popped_action, rsp.data.popped_action);
					check_field("queue_count", oldest.queue_count, rsp.data.queue_count);
					check_field("dropped_oldest", oldest.dropped_oldest, rsp.data.dropped_oldest);
				end
			end
			if (cfg.valid && cfg.ready)
				hold_min = cfg.data;
			if (req.valid && req.ready)
				pending_results.push_back(predict_item(req.data));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the button long-press event queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

import blpq_pkg::*;

module testbench;

	localparam int         DEPTH        = 8;
	localparam int         QUIET_LIMIT  = 2000;  // cycles with no beat on any channel
	localparam int         DRAIN_CYCLES = 4;
	localparam int         RANDOM_ITEMS = 95;    // per random phase
	localparam int         SHORT_HOLD   = 4;     // threshold for the directed boundary checks
	localparam func_t      FUNC_UNUSED  = 2'd3;
	localparam logic [1:0] LEN_NONE     = 2'd0;
	localparam logic [1:0] LEN_ONE      = 2'd1;
	localparam int         BTN_END_CAP  = 0;
	localparam int         BTN_DOWN     = 1;
	localparam int         BTN_UP       = 2;

	logic clk;
	logic arst_n;
	int   gap_pct;       // chance in a hundred that the sender idles a cycle
	int   stall_pct;     // chance in a hundred that the receiver stalls a cycle
	int   hold_ticks;    // long-press threshold currently loaded
	int   sent;
	int   quiet_cycles;
	int   failures;
	int   outstanding;

	blpq_in_if  req_if ();
	blpq_out_if rsp_if ();
	blpq_cfg_if cfg_if ();

	button_long_press_event_queue_unit #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	blpq_event_checker #(.QUEUE_DEPTH(DEPTH)) result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.cfg         (cfg_if),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: stall at random according to the current phase.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run when no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
		    || (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t packet_item(logic [1:0] len, logic [7:0] b0, logic [7:0] b1,
	                                         logic [7:0] b2);
		in_item_t it;
		it.func = FUNC_PACKET;
		it.byte_first = b0;
		it.byte_second = b1;
		it.byte_third = b2;
		it.packet_length = len;
		return it;
	endfunction

	// Non-packet item; the unused fields carry noise the block must ignore.
	function automatic in_item_t bare_item(func_t f);
		in_item_t it;
		it.func = f;
		it.byte_first = 8'($urandom);
		it.byte_second = 8'($urandom);
		it.byte_third = 8'($urandom);
		it.packet_length = 2'($urandom);
		return it;
	endfunction

	// A button code as a two-byte packet, or as a three-byte one with a leading zero.
	function automatic in_item_t code_item(logic [15:0] code);
		if ($urandom_range(3) == 0)
			return packet_item(LEN_THREE, 8'h00, code[15:8], code[7:0]);
		return packet_item(LEN_TWO, code[15:8], code[7:0], 8'($urandom));
	endfunction

	// Offer one item, idling first at random; return after the accepting edge.
	task automatic send(in_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= it;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send(bare_item(FUNC_TICK));
	endtask

	task automatic press_button(int b);
		send(code_item(PRESS_CODES[b]));
	endtask

	task automatic free_button(int b);
		send(code_item(RELEASE_CODES[b]));
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic settle();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_hold(int v);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= ticks_t'(v);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		hold_ticks = v;
	endtask

	// One random episode: mostly press/hold/release sequences around the threshold,
	// with pops to drain the ring, plus noise packets and broken sequences.
	task automatic random_episode();
		int pick;
		int b;
		int n;
		pick = $urandom_range(99);
		b = $urandom_range(BUTTON_COUNT - 1);
		if (pick < 45) begin
			press_button(b);
			// Land the release a little short of, on, or past the threshold.
			n = hold_ticks + $urandom_range(4) - 2;
			if (n < 0)
				n = 0;
			repeat (n) begin
				if ($urandom_range(9) == 0)
					send(bare_item(FUNC_POP));
				if ($urandom_range(19) == 0)
					press_button($urandom_range(BUTTON_COUNT - 1));
				send(bare_item(FUNC_TICK));
			end
			free_button(b);
		end else if (pick < 70) begin
			repeat ($urandom_range(1, 3)) send(bare_item(FUNC_POP));
		end else if (pick < 82) begin
			send(packet_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
		end else if (pick < 92) begin
			// Stray release with no press, or a repeated press.
			if ($urandom_range(1) == 1)
				free_button(b);
			else
				press_button(b);
		end else begin
			send(bare_item(($urandom_range(1) == 1) ? FUNC_TICK : FUNC_UNUSED));
		end
	endtask

	task automatic run_phase(int gap, int stall, int thr);
		write_hold(thr);
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		while (sent < RANDOM_ITEMS)
			random_episode();
	endtask

	initial begin
		arst_n        <= 1'b0;
		req_if.valid  <= 1'b0;
		req_if.data   <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_ticks = LONG_PRESS_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, threshold still at its reset value.
		send(bare_item(FUNC_POP));                              // pop on an empty ring
		send(packet_item(LEN_THREE, 8'hFF, 8'hFF, 8'hFF));
		send(bare_item(FUNC_UNUSED));
		send(bare_item(FUNC_TICK));
		send(packet_item(LEN_NONE, 8'hA1, 8'h01, 8'h00));       // empty packet matches nothing
		send(packet_item(LEN_ONE, 8'hA1, 8'h01, 8'h00));        // single byte matches nothing
		send(packet_item(LEN_THREE, 8'hA1, 8'h01, 8'h00));      // nonzero lead byte
		send(packet_item(LEN_THREE, 8'h00, 8'h00, 8'h00));
		free_button(BTN_END_CAP);                               // release with no press
		send(packet_item(LEN_TWO, 8'hA1, 8'h01, 8'h00));
		send(packet_item(LEN_THREE, 8'h00, 8'hA2, 8'h01));
		press_button(BTN_DOWN);                                 // repeated press restamps
		free_button(BTN_END_CAP);                               // short hold, no action
		free_button(BTN_END_CAP);                               // flag already cleared
		press_button(BTN_UP);
		send_ticks(3);
		free_button(BTN_UP);                                    // far below the reset threshold

		// Small threshold: one tick short, then exactly on it.
		write_hold(SHORT_HOLD);
		press_button(BTN_UP);
		send_ticks(SHORT_HOLD - 1);
		free_button(BTN_UP);
		press_button(BTN_UP);
		send_ticks(SHORT_HOLD);
		free_button(BTN_UP);
		repeat (6) press_button(BTN_END_CAP);                   // overflow: drop the oldest
		repeat (DEPTH) send(bare_item(FUNC_POP));               // drain past empty

		// Largest threshold: the release after a short hold does not enqueue.
		write_hold(16'hFFFF);
		press_button(BTN_UP);
		send_ticks(2);
		free_button(BTN_UP);

		// Random phases; zero and one are the low extremes of the threshold.
		run_phase(0, 0, 0);
		run_phase(73, 0, 1);
		run_phase(0, 73, $urandom_range(2, 12));
		run_phase(36, 36, $urandom_range(2, 16));

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/blpq_pkg.sv
hdl/blpq_in_if.sv
hdl/blpq_out_if.sv
hdl/blpq_cfg_if.sv
hdl/blpq_ring.sv
hdl/button_long_press_event_queue_unit.sv
sim/blpq_event_checker.sv
sim/testbench.sv
